/* sv/cbm_pkg.sv */
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
  localparam int ROM_BANK_W     = 9;
  localparam int RAM_BANK_W     = 4;
  localparam int PHYS_W         = 23;
  localparam int MBC2_RAM_W     = 9;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_TYPE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_PRESENT = 1'b1;

  // mapper types
  localparam logic [1:0] MAP_ROM_ONLY = 2'd0;
  localparam logic [1:0] MAP_MBC1     = 2'd1;
  localparam logic [1:0] MAP_MBC2     = 2'd2;
  localparam logic [1:0] MAP_MBC5     = 2'd3;

  // result targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;

  // 8 KB address regions, address[15:13]
  localparam logic [2:0] RGN_0000 = 3'd0;
  localparam logic [2:0] RGN_2000 = 3'd1;
  localparam logic [2:0] RGN_4000 = 3'd2;
  localparam logic [2:0] RGN_6000 = 3'd3;
  localparam logic [2:0] RGN_A000 = 3'd5;

  localparam logic [3:0] ENABLE_KEY = 4'hA;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        target;
    logic [PHYS_W-1:0] phys_address;
    logic              ram_write;
    logic [7:0]        data_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0] mapper_type;
    logic       ram_present;
  } cfg_t;

  typedef struct packed {
    logic                  ram_enable;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank_sel;
    logic                  banking_mode;
  } bank_state_t;

  localparam bank_state_t BANK_RESET = '{
    ram_enable:   1'b0,
    rom_bank:     ROM_BANK_W'(1),
    ram_bank_sel: '0,
    banking_mode: 1'b0
  };

endpackage

/* sv/cbm_xlate.sv */
// Address translation and bank register update for one bus access.
module cbm_xlate import cbm_pkg::*; (
  input  in_item_t    item,
  input  cfg_t        cfg,
  input  bank_state_t bank,
  output out_item_t   result,
  output bank_state_t bank_next
);

  logic [2:0]        rgn;
  logic [4:0]        lo5;
  logic [3:0]        lo4;
  logic [PHYS_W-1:0] ram_phys;
  logic              store_ok;

  assign rgn      = item.address[15:13];
  assign lo5      = (item.write_data[4:0] == 5'd0) ? 5'd1 : item.write_data[4:0];
  assign lo4      = (item.write_data[3:0] == 4'd0) ? 4'd1 : item.write_data[3:0];
  assign store_ok = bank.ram_enable && cfg.ram_present;

  always_comb begin
    if (cfg.mapper_type == MAP_MBC2) begin
      ram_phys = PHYS_W'(item.address[MBC2_RAM_W-1:0]);
    end else begin
      ram_phys = PHYS_W'({bank.ram_bank_sel, item.address[RAM_OFS_W-1:0]});
    end
  end

  always_comb begin
    bank_next         = bank;
    result.target       = TGT_NONE;
    result.phys_address = '0;
    result.ram_write    = 1'b0;
    result.data_out     = item.mode ? item.write_data : 8'd0;
    if (item.mode) begin
      unique case (cfg.mapper_type)
        MAP_MBC1: begin
          if (rgn == RGN_0000) begin
            bank_next.ram_enable = (item.write_data[3:0] == ENABLE_KEY);
          end else if (rgn == RGN_2000) begin
            if (!bank.banking_mode) begin
              bank_next.rom_bank = {2'b00, bank.rom_bank[6:5], lo5};
            end else begin
              bank_next.rom_bank = ROM_BANK_W'(lo5);
            end
          end else if (rgn == RGN_4000) begin
            if (!bank.banking_mode) begin
              bank_next.rom_bank = {2'b00, item.write_data[1:0], bank.rom_bank[4:0]};
            end else begin
              bank_next.ram_bank_sel = RAM_BANK_W'(item.write_data[1:0]);
            end
          end else if (rgn == RGN_6000) begin
            bank_next.banking_mode = item.write_data[0];
            if (!item.write_data[0]) begin
              bank_next.ram_bank_sel = '0;
            end
          end else if (rgn == RGN_A000 && store_ok) begin
            result.target       = TGT_RAM;
            result.phys_address = ram_phys;
            result.ram_write    = 1'b1;
          end
        end
        MAP_MBC2: begin
          if (rgn == RGN_0000) begin
            bank_next.ram_enable = (item.write_data[3:0] == ENABLE_KEY);
          end else if (rgn == RGN_2000) begin
            bank_next.rom_bank = ROM_BANK_W'(lo4);
          end else if (rgn == RGN_A000 && item.address[12:9] == 4'd0 && store_ok) begin
            result.target       = TGT_RAM;
            result.phys_address = ram_phys;
            result.ram_write    = 1'b1;
          end
        end
        MAP_MBC5: begin
          if (rgn == RGN_0000) begin
            bank_next.ram_enable = (item.write_data[3:0] == ENABLE_KEY);
          end else if (rgn == RGN_2000) begin
            if (!item.address[12]) begin
              bank_next.rom_bank = {bank.rom_bank[8], item.write_data};
            end else begin
              bank_next.rom_bank = {item.write_data[0], bank.rom_bank[7:0]};
            end
          end else if (rgn == RGN_4000) begin
            bank_next.ram_bank_sel = item.write_data[3:0];
          end else if (rgn == RGN_A000 && store_ok) begin
            result.target       = TGT_RAM;
            result.phys_address = ram_phys;
            result.ram_write    = 1'b1;
          end
        end
        default: begin
          // ROM only: writes ignored
        end
      endcase
    end else begin
      if (rgn == RGN_0000 || rgn == RGN_2000) begin
        result.target       = TGT_ROM;
        result.phys_address = PHYS_W'(item.address[ROM_OFS_W-1:0]);
      end else if (rgn == RGN_4000 || rgn == RGN_6000) begin
        result.target       = TGT_ROM;
        result.phys_address = PHYS_W'({bank.rom_bank, item.address[ROM_OFS_W-1:0]});
      end else if (rgn == RGN_A000 && cfg.ram_present) begin
        result.target       = TGT_RAM;
        result.phys_address = ram_phys;
      end
    end
  end

endmodule

/* sv/cbm_bank_regs.sv */
// Bank control registers: RAM enable, ROM bank, RAM bank, banking mode.
module cbm_bank_regs import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        update,
  input  bank_state_t bank_next,
  output bank_state_t bank
);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= BANK_RESET;
    end else if (update) begin
      bank <= bank_next;
    end
  end

endmodule

/* sv/cartridge_bank_mapper_top.sv */
// Cartridge bank mapper top level: input stage, translation, result stage.
// An item passes the input reg, then the result reg, and is held there on a stall.
// Throughput: one item per cycle unless stalled; translation is single-pass decode.
// Bank registers update as an item moves from the input to the result stage.
// Reset (synchronous): both stages empty, mapper ROM only, no RAM,
// RAM disabled, ROM bank 1, RAM bank 0, ROM banking mode.
module cartridge_bank_mapper_top import cbm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [1:0]             cfg_data
);

  logic        s1_valid;
  in_item_t    s1_item;
  cfg_t        cfg;
  bank_state_t bank;
  bank_state_t bank_next;
  out_item_t   result;
  logic        out_free;
  logic        advance;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mapper_type <= MAP_ROM_ONLY;
      cfg.ram_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAPPER_TYPE: cfg.mapper_type <= cfg_data;
        CFG_RAM_PRESENT: cfg.ram_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  cbm_xlate u_xlate (
    .item      (s1_item),
    .cfg       (cfg),
    .bank      (bank),
    .result    (result),
    .bank_next (bank_next)
  );

  cbm_bank_regs u_bank_regs (
    .clk       (clk),
    .rst       (rst),
    .update    (advance),
    .bank_next (bank_next),
    .bank      (bank)
  );

`ifndef SYNTHESIS
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.target == TGT_NONE |-> out_item.phys_address == '0 &&
    !out_item.ram_write)
    else $error("target none with nonzero address or store");

  a_store_to_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.ram_write |-> out_item.target == TGT_RAM)
    else $error("RAM store without RAM target");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_item))
    else $error("input stage item lost while blocked");

  a_bank_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(bank))
    else $error("bank registers changed without an item");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
